// ===== design/lsi_pkg.sv =====
`default_nettype none

package lsi_pkg;

  // Quotient bits produced by the divider, one per pipeline step
  localparam int unsigned QUO_BITS = 32;
  // Width of the fixed point result coordinates
  localparam int unsigned OUT_BITS = 32;

  localparam logic [OUT_BITS-1:0] POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Per-request control that rides alongside the divider data
  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } lsi_ctl_t;

  // Clamp a quotient magnitude and apply the sign; returns {sat, value}
  function automatic logic [OUT_BITS:0] clamp_coord(input logic [QUO_BITS-1:0] quo,
                                                    input logic ovf,
                                                    input logic neg);
    logic [OUT_BITS-1:0] limit;
    logic [OUT_BITS-1:0] mag;
    logic                sat;
    limit = neg ? NEG_LIMIT : POS_LIMIT;
    sat   = ovf || (OUT_BITS'(quo) > limit);
    mag   = sat ? limit : OUT_BITS'(quo);
    return {sat, (neg ? (~mag + OUT_BITS'(1)) : mag)};
  endfunction

endpackage

`default_nettype wire

// ===== design/lsi_div_step.sv =====
`default_nettype none

// One restoring division step for both coordinates against a shared divisor
module lsi_div_step #(
  parameter int unsigned RW    = 67,
  parameter int unsigned XW    = 35,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [RW-1:0]                 rem_x_i,
  input  wire logic [RW-1:0]                 rem_y_i,
  input  wire logic [XW-1:0]                 den_i,
  input  wire logic [lsi_pkg::QUO_BITS-1:0]  quo_x_i,
  input  wire logic [lsi_pkg::QUO_BITS-1:0]  quo_y_i,
  input  wire lsi_pkg::lsi_ctl_t             ctl_i,
  output logic      [RW-1:0]                 rem_x_o,
  output logic      [RW-1:0]                 rem_y_o,
  output logic      [XW-1:0]                 den_o,
  output logic      [lsi_pkg::QUO_BITS-1:0]  quo_x_o,
  output logic      [lsi_pkg::QUO_BITS-1:0]  quo_y_o,
  output lsi_pkg::lsi_ctl_t                  ctl_o
);

  logic [RW-1:0] dsh;
  logic          ge_x, ge_y;
  logic [RW-1:0] rem_x_d, rem_y_d;

  // trial subtract of the shifted divisor
  always_comb begin
    dsh     = RW'(den_i) << SHIFT;
    ge_x    = rem_x_i >= dsh;
    ge_y    = rem_y_i >= dsh;
    rem_x_d = ge_x ? (rem_x_i - dsh) : rem_x_i;
    rem_y_d = ge_y ? (rem_y_i - dsh) : rem_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_x_o <= rem_x_d;
      rem_y_o <= rem_y_d;
      den_o   <= den_i;
      quo_x_o <= {quo_x_i[lsi_pkg::QUO_BITS-2:0], ge_x};
      quo_y_o <= {quo_y_i[lsi_pkg::QUO_BITS-2:0], ge_y};
      ctl_o   <= ctl_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/line_segment_intersection_core.sv =====
// Throughput: one request per cycle while the output is not stalled; the divider is a 32-step restoring pipeline.
// Every stage has its own valid bit, so bubbles close up under output stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
`default_nettype none

module line_segment_intersection_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] first_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] first_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_end_y_i,
  input  wire logic                         infinite_lines_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              hit_o,
  output logic signed [lsi_pkg::OUT_BITS-1:0] point_x_o,
  output logic signed [lsi_pkg::OUT_BITS-1:0] point_y_o,
  output logic                              saturated_o
);

  localparam int unsigned QB  = lsi_pkg::QUO_BITS;
  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned XW  = 2 * COORD_BITS + 3;
  localparam int unsigned NW  = COORD_BITS + XW + 2;
  localparam int unsigned DVW = NW + FRAC_BITS;
  localparam int unsigned RW  = (DVW > XW + QB) ? DVW : XW + QB;

  localparam int unsigned S_DIFF  = 0;
  localparam int unsigned S_PROD  = 1;
  localparam int unsigned S_CROSS = 2;
  localparam int unsigned S_NORM  = 3;
  localparam int unsigned S_MUL   = 4;
  localparam int unsigned S_SUM   = 5;
  localparam int unsigned S_ABS   = 6;
  localparam int unsigned S_PREP  = 7;
  localparam int unsigned S_DIV   = 8;
  localparam int unsigned S_OUT   = S_DIV + QB;
  localparam int unsigned NST     = S_OUT + 1;

  // ---------------------------------------------------------------
  // Valid chain: a stage loads when empty or when its successor loads
  logic [NST-1:0] v_q, v_d, acc, drain;

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_vchain
      if (k == NST - 1) begin : g_last
        assign drain[k] = !out_stall_i;
        assign v_d[k]   = acc[k] ? v_q[k-1] : v_q[k];
      end else if (k == 0) begin : g_first
        assign drain[k] = acc[k+1];
        assign v_d[k]   = acc[k] ? in_valid_i : v_q[k];
      end else begin : g_mid
        assign drain[k] = acc[k+1];
        assign v_d[k]   = acc[k] ? v_q[k-1] : v_q[k];
      end
      assign acc[k] = !v_q[k] || drain[k];
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !acc[S_DIFF];
  assign out_valid_o = v_q[S_OUT];

  // ---------------------------------------------------------------
  // Direction and offset vectors
  logic signed [DW-1:0]         rx0_q, ry0_q, sx0_q, sy0_q, qx0_q, qy0_q;
  logic signed [COORD_BITS-1:0] x10_q, y10_q;
  logic                         inf0_q;

  always_ff @(posedge clk_i) begin
    if (acc[S_DIFF]) begin
      rx0_q  <= DW'(first_end_x_i) - DW'(first_start_x_i);
      ry0_q  <= DW'(first_end_y_i) - DW'(first_start_y_i);
      sx0_q  <= DW'(second_end_x_i) - DW'(second_start_x_i);
      sy0_q  <= DW'(second_end_y_i) - DW'(second_start_y_i);
      qx0_q  <= DW'(second_start_x_i) - DW'(first_start_x_i);
      qy0_q  <= DW'(second_start_y_i) - DW'(first_start_y_i);
      x10_q  <= first_start_x_i;
      y10_q  <= first_start_y_i;
      inf0_q <= infinite_lines_i;
    end
  end

  // Cross product terms
  logic signed [PW-1:0]         prs_q, psr_q, pqs1_q, pqs2_q, pqr1_q, pqr2_q;
  logic signed [DW-1:0]         rx1_q, ry1_q;
  logic signed [COORD_BITS-1:0] x11_q, y11_q;
  logic                         inf1_q;

  always_ff @(posedge clk_i) begin
    if (acc[S_PROD]) begin
      prs_q  <= rx0_q * sy0_q;
      psr_q  <= ry0_q * sx0_q;
      pqs1_q <= qx0_q * sy0_q;
      pqs2_q <= qy0_q * sx0_q;
      pqr1_q <= qx0_q * ry0_q;
      pqr2_q <= qy0_q * rx0_q;
      rx1_q  <= rx0_q;
      ry1_q  <= ry0_q;
      x11_q  <= x10_q;
      y11_q  <= y10_q;
      inf1_q <= inf0_q;
    end
  end

  // Determinants
  logic signed [XW-1:0]         den2_q, tn2_q, un2_q;
  logic signed [DW-1:0]         rx2_q, ry2_q;
  logic signed [COORD_BITS-1:0] x12_q, y12_q;
  logic                         inf2_q;

  always_ff @(posedge clk_i) begin
    if (acc[S_CROSS]) begin
      den2_q <= XW'(prs_q) - XW'(psr_q);
      tn2_q  <= XW'(pqs1_q) - XW'(pqs2_q);
      un2_q  <= XW'(pqr1_q) - XW'(pqr2_q);
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;
      x12_q  <= x11_q;
      y12_q  <= y11_q;
      inf2_q <= inf1_q;
    end
  end

  // Make the divisor positive
  logic signed [XW-1:0]         den3_q, tn3_q, un3_q;
  logic                         nz3_q;
  logic signed [DW-1:0]         rx3_q, ry3_q;
  logic signed [COORD_BITS-1:0] x13_q, y13_q;
  logic                         inf3_q;

  always_ff @(posedge clk_i) begin
    if (acc[S_NORM]) begin
      den3_q <= den2_q[XW-1] ? -den2_q : den2_q;
      tn3_q  <= den2_q[XW-1] ? -tn2_q : tn2_q;
      un3_q  <= den2_q[XW-1] ? -un2_q : un2_q;
      nz3_q  <= den2_q != '0;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      x13_q  <= x12_q;
      y13_q  <= y12_q;
      inf3_q <= inf2_q;
    end
  end

  // Hit test and numerator products
  logic                          hit3;
  logic signed [COORD_BITS+XW-1:0] mx4_q, my4_q;
  logic signed [DW+XW-1:0]       mrx4_q, mry4_q;
  logic [XW-1:0]                 den4_q;
  logic                          hit4_q;

  assign hit3 = nz3_q && (inf3_q || (!tn3_q[XW-1] && (tn3_q <= den3_q) &&
                                     !un3_q[XW-1] && (un3_q <= den3_q)));

  always_ff @(posedge clk_i) begin
    if (acc[S_MUL]) begin
      mx4_q  <= x13_q * den3_q;
      my4_q  <= y13_q * den3_q;
      mrx4_q <= rx3_q * tn3_q;
      mry4_q <= ry3_q * tn3_q;
      den4_q <= den3_q;
      hit4_q <= hit3;
    end
  end

  // Numerators
  logic signed [NW-1:0] nx5_q, ny5_q;
  logic [XW-1:0]        den5_q;
  logic                 hit5_q;

  always_ff @(posedge clk_i) begin
    if (acc[S_SUM]) begin
      nx5_q  <= NW'(mx4_q) + NW'(mrx4_q);
      ny5_q  <= NW'(my4_q) + NW'(mry4_q);
      den5_q <= den4_q;
      hit5_q <= hit4_q;
    end
  end

  // Sign and magnitude
  logic [NW-1:0] mx6_q, my6_q;
  logic          negx6_q, negy6_q;
  logic [XW-1:0] den6_q;
  logic          hit6_q;

  always_ff @(posedge clk_i) begin
    if (acc[S_ABS]) begin
      mx6_q   <= nx5_q[NW-1] ? NW'(-nx5_q) : NW'(nx5_q);
      my6_q   <= ny5_q[NW-1] ? NW'(-ny5_q) : NW'(ny5_q);
      negx6_q <= nx5_q[NW-1];
      negy6_q <= ny5_q[NW-1];
      den6_q  <= den5_q;
      hit6_q  <= hit5_q;
    end
  end

  // Scale dividends and flag quotients that cannot fit in QB bits
  logic [RW:0]       dvx, dvy, dtop;
  logic [RW-1:0]     rem_x7_q, rem_y7_q;
  logic [XW-1:0]     den7_q;
  lsi_pkg::lsi_ctl_t ctl7_q;
  logic [RW-1:0]     rem_x_w [QB+1];
  logic [RW-1:0]     rem_y_w [QB+1];
  logic [XW-1:0]     den_w   [QB+1];
  logic [QB-1:0]     quo_x_w [QB+1];
  logic [QB-1:0]     quo_y_w [QB+1];
  lsi_pkg::lsi_ctl_t ctl_w   [QB+1];

  always_comb begin
    dvx  = (RW+1)'(mx6_q) << FRAC_BITS;
    dvy  = (RW+1)'(my6_q) << FRAC_BITS;
    dtop = (RW+1)'(den6_q) << QB;
  end

  always_ff @(posedge clk_i) begin
    if (acc[S_PREP]) begin
      rem_x7_q     <= RW'(dvx);
      rem_y7_q     <= RW'(dvy);
      den7_q       <= den6_q;
      ctl7_q.hit   <= hit6_q;
      ctl7_q.neg_x <= negx6_q;
      ctl7_q.neg_y <= negy6_q;
      ctl7_q.ovf_x <= dvx >= dtop;
      ctl7_q.ovf_y <= dvy >= dtop;
    end
  end

  // first divider step starts from the scaled dividends
  assign rem_x_w[0] = rem_x7_q;
  assign rem_y_w[0] = rem_y7_q;
  assign den_w[0]   = den7_q;
  assign quo_x_w[0] = '0;
  assign quo_y_w[0] = '0;
  assign ctl_w[0]   = ctl7_q;

  // Divider: one quotient bit per stage, most significant first
  genvar i;
  generate
    for (i = 0; i < QB; i++) begin : g_div
      lsi_div_step #(
        .RW   (RW),
        .XW   (XW),
        .SHIFT(QB - 1 - i)
      ) u_step (
        .clk_i  (clk_i),
        .en_i   (acc[S_DIV+i]),
        .rem_x_i(rem_x_w[i]),
        .rem_y_i(rem_y_w[i]),
        .den_i  (den_w[i]),
        .quo_x_i(quo_x_w[i]),
        .quo_y_i(quo_y_w[i]),
        .ctl_i  (ctl_w[i]),
        .rem_x_o(rem_x_w[i+1]),
        .rem_y_o(rem_y_w[i+1]),
        .den_o  (den_w[i+1]),
        .quo_x_o(quo_x_w[i+1]),
        .quo_y_o(quo_y_w[i+1]),
        .ctl_o  (ctl_w[i+1])
      );
    end
  endgenerate

  // Clamp, sign and output register
  logic [lsi_pkg::OUT_BITS:0] cx, cy;
  lsi_pkg::lsi_ctl_t          ctl_f;

  always_comb begin
    ctl_f = ctl_w[QB];
    cx    = lsi_pkg::clamp_coord(quo_x_w[QB], ctl_f.ovf_x, ctl_f.neg_x);
    cy    = lsi_pkg::clamp_coord(quo_y_w[QB], ctl_f.ovf_y, ctl_f.neg_y);
  end

  always_ff @(posedge clk_i) begin
    if (acc[S_OUT]) begin
      hit_o       <= ctl_f.hit;
      point_x_o   <= ctl_f.hit ? cx[lsi_pkg::OUT_BITS-1:0] : '0;
      point_y_o   <= ctl_f.hit ? cy[lsi_pkg::OUT_BITS-1:0] : '0;
      saturated_o <= ctl_f.hit && (cx[lsi_pkg::OUT_BITS] || cy[lsi_pkg::OUT_BITS]);
    end
  end

`ifndef SYNTHESIS
  // a miss carries an all-zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> point_x_o == '0 && point_y_o == '0 && !saturated_o)
    else $error("miss result with nonzero fields");

  // saturation leaves at least one coordinate at a limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      point_x_o == lsi_pkg::POS_LIMIT || point_x_o == lsi_pkg::NEG_LIMIT ||
      point_y_o == lsi_pkg::POS_LIMIT || point_y_o == lsi_pkg::NEG_LIMIT)
    else $error("saturated without clamped coordinate");

  // input stalls only when the whole pipe is full behind a stalled output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && (&v_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
